/* rtl/fpr_pkg.sv */
// fpr_pkg: shared types and constants of the framed packet receiver
// no dependencies
package fpr_pkg;

    localparam int IDX_W = 4;
    localparam logic [7:0] FRAME_START = 8'hAA;
    localparam logic [7:0] FRAME_END = 8'h55;
    localparam int HEADER_BYTES = 2;
    localparam int FRAME_OVERHEAD = 3;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_READ = 2'd1,
        CMD_WRITE_READY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_OPCODE = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA = 3'd3,
        PH_CHECK = 3'd4,
        PH_END = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [IDX_W-1:0] read_index;
        logic ready_value;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic frame_flag;
        logic [2:0] parser_phase;
    } out_t;

    typedef struct packed {
        logic en;
        logic [IDX_W-1:0] addr;
        logic [7:0] data;
    } store_wr_t;

endpackage

/* rtl/fpr_in_stage.sv */
// fpr_in_stage: input register of the receiver pipeline
// depends on fpr_pkg
module fpr_in_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  fpr_pkg::in_t in_data,
    output logic item_valid,
    output fpr_pkg::in_t item_data,
    input  logic advance
);
    import fpr_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t data_reg;

    assign in_ready = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

/* rtl/fpr_store.sv */
// fpr_store: packet store, one write port and one read port
// depends on fpr_pkg
module fpr_store #(
    parameter int DEPTH = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  fpr_pkg::store_wr_t wr,
    input  logic [fpr_pkg::IDX_W-1:0] rd_index,
    output logic [7:0] rd_data
);
    import fpr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem_reg [DEPTH];
    logic wr_hit;
    logic rd_hit;

    assign wr_hit = wr.en && ({1'b0, wr.addr} < (IDX_W + 1)'(DEPTH));
    assign rd_hit = {1'b0, rd_index} < (IDX_W + 1)'(DEPTH);
    assign rd_data = rd_hit ? mem_reg[rd_index[AW-1:0]] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                mem_reg[i] <= 8'd0;
            end
        end
        else if (wr_hit)
        begin
            mem_reg[wr.addr[AW-1:0]] <= wr.data;
        end
    end

endmodule

/* rtl/fpr_parser.sv */
// fpr_parser: frame phase machine, checksums, ready flag and result forming
// depends on fpr_pkg
module fpr_parser #(
    parameter int STORE_BYTES = 10,
    parameter int STORE_DEPTH = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  fpr_pkg::in_t item,
    input  logic [7:0] store_rd_data,
    output fpr_pkg::store_wr_t store_wr,
    output fpr_pkg::out_t result
);
    import fpr_pkg::*;

    localparam int LIMIT = STORE_BYTES - FRAME_OVERHEAD;
    localparam int CNT_W = $clog2(STORE_BYTES);
    localparam int PW = CNT_W + 1;

    phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [7:0] rchk_reg, rchk_next;
    logic [7:0] cchk_reg, cchk_next;
    logic ready_reg, ready_next;
    logic [CNT_W-1:0] count_inc;
    logic [PW-1:0] pos;
    logic [7:0] b;

    assign b = item.rx_byte;
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next = len_reg;
        rchk_next = rchk_reg;
        cchk_next = cchk_reg;
        ready_next = ready_reg;
        pos = '0;
        store_wr = '0;
        store_wr.data = b;
        result = '0;

        case (cmd_t'(item.command))
            CMD_BYTE:
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (b == FRAME_START)
                        begin
                            phase_next = PH_OPCODE;
                            count_next = '0;
                            cchk_next = 8'd0;
                            rchk_next = 8'd0;
                        end
                    end
                    PH_OPCODE:
                    begin
                        store_wr.en = 1'b1;
                        store_wr.addr = IDX_W'(0);
                        cchk_next = cchk_reg ^ b;
                        phase_next = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        store_wr.en = 1'b1;
                        store_wr.addr = IDX_W'(1);
                        if (b > 8'(LIMIT))
                        begin
                            phase_next = PH_START;
                            count_next = '0;
                        end
                        else
                        begin
                            len_next = CNT_W'(b);
                            cchk_next = cchk_reg ^ b;
                            phase_next = (b == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (count_reg >= CNT_W'(LIMIT))
                        begin
                            phase_next = PH_START;
                            count_next = '0;
                        end
                        else
                        begin
                            pos = PW'(count_reg) + PW'(HEADER_BYTES);
                            store_wr.en = int'(pos) < STORE_DEPTH;
                            store_wr.addr = IDX_W'(pos);
                            cchk_next = cchk_reg ^ b;
                            count_next = count_inc;
                            if (count_inc == len_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        rchk_next = b;
                        pos = PW'(len_reg) + PW'(HEADER_BYTES);
                        store_wr.en = int'(pos) < STORE_DEPTH;
                        store_wr.addr = IDX_W'(pos);
                        phase_next = PH_END;
                    end
                    PH_END:
                    begin
                        if (b == FRAME_END && cchk_reg == rchk_reg)
                        begin
                            ready_next = 1'b1;
                        end
                        phase_next = PH_START;
                        count_next = '0;
                    end
                    default:
                    begin
                        phase_next = PH_START;
                        count_next = '0;
                    end
                endcase
            end
            CMD_READ:
            begin
                result.read_data = store_rd_data;
            end
            CMD_WRITE_READY:
            begin
                ready_next = item.ready_value;
            end
            default:
            begin
                result.read_data = 8'd0;
            end
        endcase

        store_wr.en = store_wr.en && fire;
        result.frame_flag = ready_next;
        result.parser_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            count_reg <= '0;
            len_reg <= '0;
            rchk_reg <= 8'd0;
            cchk_reg <= 8'd0;
            ready_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg <= len_next;
            rchk_reg <= rchk_next;
            cchk_reg <= cchk_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* rtl/fpr_out_stage.sv */
// fpr_out_stage: result register toward the output channel
// depends on fpr_pkg
module fpr_out_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic advance,
    input  fpr_pkg::out_t result,
    output logic out_valid,
    input  logic out_ready,
    output fpr_pkg::out_t out_data
);
    import fpr_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    assign advance = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

endmodule

/* rtl/framed_packet_receiver.sv */
// framed_packet_receiver: byte framed packet parser with xor checksum
// path: input register, then parser and store read (combinational), then result register toward the output
// throughput: one item per cycle while the output channel accepts results; out_ready low stalls the pipeline
// reset: phase, counters, checksums, ready flag and packet store all clear to zero
// depends on fpr_pkg, fpr_in_stage, fpr_store, fpr_parser, fpr_out_stage
module framed_packet_receiver #(
    parameter int STORE_BYTES = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  fpr_pkg::in_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output fpr_pkg::out_t out_data
);
    import fpr_pkg::*;

    localparam int ADDR_SPAN = 1 << IDX_W;
    localparam int STORE_DEPTH = (STORE_BYTES < ADDR_SPAN) ? STORE_BYTES : ADDR_SPAN;

    logic item_valid;
    in_t item_data;
    logic advance;
    store_wr_t store_wr;
    logic [7:0] store_rd_data;
    out_t result;

    fpr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_data  (item_data),
        .advance    (advance)
    );

    fpr_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (store_wr),
        .rd_index (item_data.read_index),
        .rd_data  (store_rd_data)
    );

    fpr_parser #(
        .STORE_BYTES (STORE_BYTES),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (item_data),
        .store_rd_data (store_rd_data),
        .store_wr      (store_wr),
        .result        (result)
    );

    fpr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
